// ===== sv/hsse_pkg.sv =====
// shared types, constants and helpers of the hall sector speed and angle estimator
package hsse_pkg;

  // widths
  localparam int COUNT_WIDTH = 24;
  localparam int TS_W        = 32;
  localparam int OFFSET_W    = 20;
  localparam int SPEED_W     = 32;
  localparam int ANGLE_W     = 24;
  localparam int FINE_W      = 17;
  localparam int SECTOR_W    = 3;
  localparam int SUM_W       = SPEED_W + 1;
  localparam int DEN_W       = COUNT_WIDTH + TS_W;
  localparam int PROD_W      = TS_W + SUM_W;
  localparam int UNIT_W      = (DEN_W + 1 > PROD_W) ? DEN_W + 1 : PROD_W;
  localparam int OPND_W      = (COUNT_WIDTH > SUM_W) ? COUNT_WIDTH : SUM_W;
  localparam int CNT_W       = $clog2(OPND_W + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = TS_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET  = 1'd1;

  // register reset values
  localparam logic [TS_W-1:0]     TS_RESET     = 32'd429497;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

  // fixed point constants
  localparam logic [FINE_W-1:0] PI_THIRD_Q16     = 17'd68629;
  localparam logic [63:0]       TWO_PI_THIRD_Q48 = 64'd589519812669037;

  // configuration seen by the core
  typedef struct packed {
    logic [TS_W-1:0]            sample_period;
    logic signed [OFFSET_W-1:0] angle_offset;
  } hsse_cfg_t;

  // one result beat
  typedef struct packed {
    logic [SECTOR_W-1:0]       sector;
    logic [SPEED_W-1:0]        speed;
    logic signed [ANGLE_W-1:0] angle;
  } hsse_res_t;

  // hall code (a,b,c weighted 4,2,1) to sector, 0 for an invalid code
  function automatic logic [SECTOR_W-1:0] decode_hall(input logic [2:0] code);
    logic [SECTOR_W-1:0] s;
    case (code)
      3'd4:    s = 3'd1;
      3'd6:    s = 3'd2;
      3'd2:    s = 3'd3;
      3'd3:    s = 3'd4;
      3'd1:    s = 3'd5;
      3'd5:    s = 3'd6;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // (sector - 1) * pi/3 - pi/6 in Q.16
  function automatic logic signed [ANGLE_W-1:0] angle_base(input logic [SECTOR_W-1:0] sec);
    logic signed [ANGLE_W-1:0] b;
    case (sec)
      3'd0:    b = -24'sd102944;
      3'd1:    b = -24'sd34315;
      3'd2:    b = 24'sd34314;
      3'd3:    b = 24'sd102943;
      3'd4:    b = 24'sd171572;
      3'd5:    b = 24'sd240201;
      3'd6:    b = 24'sd308830;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/hsse_if.sv =====
// valid/ready channel interfaces for hall sample beats and estimate beats

interface hsse_in_if;
  logic valid;
  logic ready;
  logic hall_a;
  logic hall_b;
  logic hall_c;

  modport source (output valid, output hall_a, output hall_b, output hall_c, input ready);
  modport sink   (input valid, input hall_a, input hall_b, input hall_c, output ready);
endinterface

interface hsse_out_if;
  logic                                valid;
  logic                                ready;
  logic [hsse_pkg::SECTOR_W-1:0]       sector;
  logic [hsse_pkg::SPEED_W-1:0]        speed;
  logic signed [hsse_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, output sector, output speed, output angle, input ready);
  modport sink   (input valid, input sector, input speed, input angle, output ready);
endinterface

// ===== sv/hall_sector_speed_angle_estimator_top.sv =====
// top level: configuration registers, output register and the estimator core
//
// Hall sector, speed and angle estimator.
// in_i carries one beat per sample tick with the three hall levels; out_o
// returns one beat per input beat with sector (0 = invalid code), speed
// (unsigned Q16.16 rad/s) and angle (signed Q.16 rad, offset included).
// The configuration port writes sample_period (index 0) or angle_offset
// (index 1) at any edge with cfg_we_i high; write only while idle.
// Sequence: all work runs through one shared adder/subtractor. A beat with
// no speed update due runs the speed sum, the bit-serial trapezoid multiply
// Ts*sum, the fine angle add and its clamp at pi/3, and the sector base and
// offset adds into the result register. On every second sector change the
// bit-serial ticks*Ts multiply, the rounding add, the saturation check and
// the restoring divide run first; a saturating speed skips the divide.
// in_i.ready is high while the core is idle, so a beat waits for the last
// to end; a new beat is accepted even while the previous result still waits
// in the output register. If out_o.ready stays low the core holds its
// finished result and stops taking beats until the output register frees up.
// Reset clears all estimator state to zero, loads the register defaults and
// empties the output register.
module hall_sector_speed_angle_estimator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  hsse_in_if.sink                          in_i,
  hsse_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [hsse_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hsse_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  hsse_pkg::hsse_cfg_t cfg_q;
  hsse_pkg::hsse_res_t core_res;
  hsse_pkg::hsse_res_t out_res_q;
  logic                out_valid_q;
  logic                core_idle;
  logic                core_res_valid;
  logic                out_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_period <= hsse_pkg::TS_RESET;
      cfg_q.angle_offset  <= hsse_pkg::OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hsse_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data_i;
        hsse_pkg::REG_ANGLE_OFFSET:
          cfg_q.angle_offset <= cfg_data_i[hsse_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  hsse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_i.valid),
    .hall_code_i ({in_i.hall_a, in_i.hall_b, in_i.hall_c}),
    .cfg_i       (cfg_q),
    .idle_o      (core_idle),
    .res_valid_o (core_res_valid),
    .res_take_i  (out_take),
    .res_o       (core_res)
  );

  assign in_i.ready = core_idle;

  // output register, loaded when empty or being drained
  assign out_take = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_valid && out_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_valid && out_take) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sector = out_res_q.sector;
  assign out_o.speed  = out_res_q.speed;
  assign out_o.angle  = out_res_q.angle;

endmodule

// ===== sv/hsse_addsub.sv =====
// shared wide adder/subtractor used for every multiply, divide, compare and sum step
module hsse_addsub (
  input  logic [hsse_pkg::UNIT_W-1:0] a_i,
  input  logic [hsse_pkg::UNIT_W-1:0] b_i,
  input  logic                        sub_i,
  output logic [hsse_pkg::UNIT_W-1:0] res_o,
  output logic                        carry_o
);

  logic [hsse_pkg::UNIT_W-1:0] b_eff;
  logic [hsse_pkg::UNIT_W:0]   full;

  // a + b, or a - b as a + ~b + 1; carry set on subtract means a >= b
  assign b_eff   = sub_i ? ~b_i : b_i;
  assign full    = {1'b0, a_i} + {1'b0, b_eff} + {{hsse_pkg::UNIT_W{1'b0}}, sub_i};
  assign res_o   = full[hsse_pkg::UNIT_W-1:0];
  assign carry_o = full[hsse_pkg::UNIT_W];

endmodule

// ===== sv/hsse_core.sv =====
// sequencer and state of the estimator around one shared adder/subtractor
module hsse_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0]            hall_code_i,
  input  hsse_pkg::hsse_cfg_t   cfg_i,
  output logic                  idle_o,
  output logic                  res_valid_o,
  input  logic                  res_take_i,
  output hsse_pkg::hsse_res_t   res_o
);

  localparam int UW = hsse_pkg::UNIT_W;
  localparam int OW = hsse_pkg::OPND_W;
  localparam int CW = hsse_pkg::COUNT_WIDTH;
  localparam int QW = hsse_pkg::SPEED_W;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_MUL  = 12'b0000_0000_0010,
    S_DADD = 12'b0000_0000_0100,
    S_DCHK = 12'b0000_0000_1000,
    S_DIV  = 12'b0000_0001_0000,
    S_TSUM = 12'b0000_0010_0000,
    S_TMUL = 12'b0000_0100_0000,
    S_FADD = 12'b0000_1000_0000,
    S_CLMP = 12'b0001_0000_0000,
    S_ANG1 = 12'b0010_0000_0000,
    S_ANG2 = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_e;

  state_e                            state_q, state_d;
  logic [UW-1:0]                     acc_q, acc_d;
  logic [OW-1:0]                     opnd_q, opnd_d;
  logic [QW-1:0]                     qsh_q, qsh_d;
  logic [hsse_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [hsse_pkg::DEN_W-1:0]        den_q, den_d;
  logic [QW-1:0]                     spd_q, spd_d;
  logic [hsse_pkg::FINE_W-1:0]       fine_q, fine_d;
  logic [CW-1:0]                     tick_q, tick_d;
  logic                              chg_q, chg_d;
  logic [hsse_pkg::SECTOR_W-1:0]     sec_q, sec_d;
  logic [hsse_pkg::SECTOR_W-1:0]     last_sec_q, last_sec_d;
  logic [QW-1:0]                     last_spd_q, last_spd_d;

  logic [UW-1:0]                     op_a, op_b, op_res;
  logic                              op_sub, op_carry;
  logic [UW-1:0]                     mul_add;
  logic [hsse_pkg::SECTOR_W-1:0]     dec_sec;
  logic [CW-1:0]                     tick_inc;
  logic signed [hsse_pkg::ANGLE_W-1:0] base;

  hsse_addsub u_addsub (
    .a_i     (op_a),
    .b_i     (op_b),
    .sub_i   (op_sub),
    .res_o   (op_res),
    .carry_o (op_carry)
  );

  // decode and saturating tick count for the incoming sample
  assign dec_sec  = hsse_pkg::decode_hall(hall_code_i);
  assign tick_inc = (tick_q == {CW{1'b1}}) ? tick_q : tick_q + CW'(1);
  assign mul_add  = opnd_q[OW-1] ? UW'(cfg_i.sample_period) : '0;
  assign base     = hsse_pkg::angle_base(sec_q);

  // sequencer
  always_comb begin
    op_a       = '0;
    op_b       = '0;
    op_sub     = 1'b0;
    state_d    = state_q;
    acc_d      = acc_q;
    opnd_d     = opnd_q;
    qsh_d      = qsh_q;
    cnt_d      = cnt_q;
    den_d      = den_q;
    spd_d      = spd_q;
    fine_d     = fine_q;
    tick_d     = tick_q;
    chg_d      = chg_q;
    sec_d      = sec_q;
    last_sec_d = last_sec_q;
    last_spd_d = last_spd_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          sec_d  = dec_sec;
          tick_d = tick_inc;
          spd_d  = last_spd_q;
          acc_d  = '0;
          state_d = S_TSUM;
          if (dec_sec != last_sec_q) begin
            fine_d = '0;
            if (chg_q) begin
              // second change: new speed from the elapsed ticks
              tick_d  = '0;
              chg_d   = 1'b0;
              opnd_d  = OW'(tick_inc) << (OW - CW);
              cnt_d   = hsse_pkg::CNT_W'(CW);
              state_d = S_MUL;
            end else begin
              chg_d = 1'b1;
            end
          end
        end
      end
      S_MUL: begin
        // ticks * Ts, one multiplier bit per cycle
        op_a   = acc_q << 1;
        op_b   = mul_add;
        acc_d  = op_res;
        opnd_d = opnd_q << 1;
        cnt_d  = cnt_q - hsse_pkg::CNT_W'(1);
        if (cnt_q == hsse_pkg::CNT_W'(1)) begin
          den_d   = op_res[hsse_pkg::DEN_W-1:0];
          state_d = S_DADD;
        end
      end
      S_DADD: begin
        // numerator with half the divisor for rounding
        op_a    = UW'(hsse_pkg::TWO_PI_THIRD_Q48);
        op_b    = UW'(den_q >> 1);
        acc_d   = op_res;
        state_d = S_DCHK;
      end
      S_DCHK: begin
        // quotient would not fit in the speed width (or divisor is zero)
        op_a   = acc_q >> QW;
        op_b   = UW'(den_q);
        op_sub = 1'b1;
        if (op_carry) begin
          spd_d   = '1;
          state_d = S_TSUM;
        end else begin
          acc_d   = acc_q >> QW;
          qsh_d   = acc_q[QW-1:0];
          cnt_d   = hsse_pkg::CNT_W'(QW);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        op_a   = {acc_q[UW-2:0], qsh_q[QW-1]};
        op_b   = UW'(den_q);
        op_sub = 1'b1;
        acc_d  = op_carry ? op_res : op_a;
        qsh_d  = {qsh_q[QW-2:0], op_carry};
        cnt_d  = cnt_q - hsse_pkg::CNT_W'(1);
        if (cnt_q == hsse_pkg::CNT_W'(1)) begin
          spd_d   = {qsh_q[QW-2:0], op_carry};
          state_d = S_TSUM;
        end
      end
      S_TSUM: begin
        // speed + last speed for the trapezoid step
        op_a    = UW'(spd_q);
        op_b    = UW'(last_spd_q);
        opnd_d  = OW'(op_res[hsse_pkg::SUM_W-1:0]) << (OW - hsse_pkg::SUM_W);
        acc_d   = '0;
        cnt_d   = hsse_pkg::CNT_W'(hsse_pkg::SUM_W);
        state_d = S_TMUL;
      end
      S_TMUL: begin
        // Ts * sum, one multiplier bit per cycle
        op_a   = acc_q << 1;
        op_b   = mul_add;
        acc_d  = op_res;
        opnd_d = opnd_q << 1;
        cnt_d  = cnt_q - hsse_pkg::CNT_W'(1);
        if (cnt_q == hsse_pkg::CNT_W'(1)) begin
          state_d = S_FADD;
        end
      end
      S_FADD: begin
        // fine angle plus floor(product / 2^33)
        op_a    = UW'(fine_q);
        op_b    = acc_q >> hsse_pkg::SUM_W;
        acc_d   = op_res;
        state_d = S_CLMP;
      end
      S_CLMP: begin
        // clamp at pi/3
        op_a    = UW'(hsse_pkg::PI_THIRD_Q16);
        op_b    = acc_q;
        op_sub  = 1'b1;
        fine_d  = op_carry ? acc_q[hsse_pkg::FINE_W-1:0] : hsse_pkg::PI_THIRD_Q16;
        state_d = S_ANG1;
      end
      S_ANG1: begin
        // sector base plus fine angle
        op_a    = {{(UW - hsse_pkg::ANGLE_W){base[hsse_pkg::ANGLE_W-1]}}, base};
        op_b    = UW'(fine_q);
        acc_d   = op_res;
        state_d = S_ANG2;
      end
      S_ANG2: begin
        // plus the sign extended offset
        op_a    = acc_q;
        op_b    = {{(UW - hsse_pkg::OFFSET_W){cfg_i.angle_offset[hsse_pkg::OFFSET_W-1]}},
                   cfg_i.angle_offset};
        acc_d   = op_res;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (res_take_i) begin
          last_sec_d = sec_q;
          last_spd_d = spd_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      fine_q     <= '0;
      tick_q     <= '0;
      chg_q      <= 1'b0;
      last_sec_q <= '0;
      last_spd_q <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      fine_q     <= fine_d;
      tick_q     <= tick_d;
      chg_q      <= chg_d;
      last_sec_q <= last_sec_d;
      last_spd_q <= last_spd_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    opnd_q <= opnd_d;
    qsh_q  <= qsh_d;
    den_q  <= den_d;
    spd_q  <= spd_d;
    sec_q  <= sec_d;
  end

  assign idle_o       = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_FIN);
  assign res_o.sector = sec_q;
  assign res_o.speed  = spd_q;
  assign res_o.angle  = acc_q[hsse_pkg::ANGLE_W-1:0];

  // checks
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> (state_q != S_IDLE))
    else $error("core stayed idle after an accepted sample");

  a_fine_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (fine_q <= hsse_pkg::PI_THIRD_Q16))
    else $error("fine angle above pi/3");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (acc_q < UW'(den_q)))
    else $error("division remainder not below divisor");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_MUL || state_q == S_TMUL) |-> (cnt_q != '0))
    else $error("iteration counter ran out inside a loop");

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench of the hall sector speed and angle estimator top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsse_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 4;
  // watchdog limit covers the slowest beat plus the input gap and output stall
  localparam int WDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_BEATS = 1800;
  localparam int MAX_REPORTS  = 10;
  localparam int PI_SIXTH_Q16 = 34315;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  // one row of the directed table: a hall beat or a register setting
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  hall;
    logic [31:0] ts;
    logic [31:0] ofs;
    logic        typed;
    hsse_res_t   want;
  } row_t;

  localparam hsse_res_t NO_WANT = '0;

  // hall patterns a,b,c in forward rotation order
  localparam logic [2:0] ROTATION [6] = '{3'b100, 3'b110, 3'b010, 3'b011, 3'b001, 3'b101};

  localparam row_t DIRECTED [29] = '{
    // after reset: invalid codes hold sector 0, then the first change
    '{ROW_BEAT, 3'b000, 32'd0, 32'd0, 1'b1, '{3'd0, 32'd0, -24'sd102944}},
    '{ROW_BEAT, 3'b111, 32'd0, 32'd0, 1'b1, '{3'd0, 32'd0, -24'sd102944}},
    '{ROW_BEAT, 3'b100, 32'd0, 32'd0, 1'b1, '{3'd1, 32'd0, -24'sd34315}},
    // one full forward turn, then a dwell in sector 1
    '{ROW_BEAT, 3'b110, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b010, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b011, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b001, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b101, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b100, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b100, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b100, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b110, 32'd0, 32'd0, 1'b0, NO_WANT},
    // longest sample period and largest offset: fine angle clamps
    '{ROW_CFG,  3'b000, 32'hFFFF_FFFF, 32'h0007_FFFF, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b010, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b010, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b010, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b011, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b011, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b001, 32'd0, 32'd0, 1'b0, NO_WANT},
    // zero sample period, most negative offset with junk in the upper bits
    '{ROW_CFG,  3'b000, 32'd0, 32'hFFF8_0000, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b101, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b100, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b110, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b000, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b010, 32'd0, 32'd0, 1'b0, NO_WANT},
    // shortest sample period: speed saturates
    '{ROW_CFG,  3'b000, 32'd1, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b011, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, 3'b001, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_CFG,  3'b000, TS_RESET, 32'd0, 1'b0, NO_WANT}
  };

  logic clk;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  hsse_in_if  in_if ();
  hsse_out_if out_if ();

  hall_sector_speed_angle_estimator_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor copy of the registers and the estimator state
  logic [TS_W-1:0]            ts_q;
  logic signed [OFFSET_W-1:0] ofs_q;
  logic [COUNT_WIDTH-1:0]     tick_cnt_q;
  logic                       odd_change_q;
  logic [SECTOR_W-1:0]        prev_sector_q;
  logic [FINE_W-1:0]          fine_q;
  logic [SPEED_W-1:0]         prev_speed_q;

  hsse_res_t pending_estimates [$];
  int        mismatch_cnt;
  int        idle_cycles;
  bit        stall_en;

  // next estimate for one hall beat, advancing the predictor state
  function automatic hsse_res_t estimate_next(input logic [2:0] hall);
    logic [SECTOR_W-1:0] sec;
    logic [SPEED_W-1:0]  spd;
    logic [63:0]         den;
    logic [63:0]         quo;
    logic [SUM_W-1:0]    sum;
    logic [95:0]         prod;
    logic [63:0]         fine_acc;
    int                  ang;
    hsse_res_t           res;
    case (hall)
      3'b100:  sec = 3'd1;
      3'b110:  sec = 3'd2;
      3'b010:  sec = 3'd3;
      3'b011:  sec = 3'd4;
      3'b001:  sec = 3'd5;
      3'b101:  sec = 3'd6;
      default: sec = 3'd0;
    endcase
    spd = prev_speed_q;
    fine_acc = 64'(fine_q);
    if (tick_cnt_q != '1) tick_cnt_q = tick_cnt_q + 1'b1;
    // sector change clears the fine angle, every second one updates speed
    if (sec != prev_sector_q) begin
      fine_acc = '0;
      if (odd_change_q) begin
        den = 64'(tick_cnt_q) * 64'(ts_q);
        if (den == '0) begin
          spd = '1;
        end else begin
          quo = (TWO_PI_THIRD_Q48 + (den >> 1)) / den;
          spd = (quo > 64'hFFFF_FFFF) ? '1 : quo[SPEED_W-1:0];
        end
        tick_cnt_q = '0;
        odd_change_q = 1'b0;
      end else begin
        odd_change_q = 1'b1;
      end
    end
    // trapezoid step floor(ts * (speed + last speed) / 2^33), clamped at pi/3
    sum = {1'b0, spd} + {1'b0, prev_speed_q};
    prod = 96'(ts_q) * 96'(sum);
    fine_acc = fine_acc + 64'(prod >> 33);
    if (fine_acc > 64'(PI_THIRD_Q16)) fine_acc = 64'(PI_THIRD_Q16);
    ang = (int'(sec) - 1) * int'(PI_THIRD_Q16) + int'(fine_acc[FINE_W-1:0])
          - PI_SIXTH_Q16 + int'(ofs_q);
    prev_sector_q = sec;
    fine_q = fine_acc[FINE_W-1:0];
    prev_speed_q = spd;
    res.sector = sec;
    res.speed = spd;
    res.angle = ANGLE_W'(ang);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_cnt < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // one input beat; entered and left just after a falling edge
  task automatic send_hall(input logic [2:0] hall, input logic typed, input hsse_res_t want);
    int        gap;
    hsse_res_t pred;
    gap = stall_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.hall_a <= hall[2];
    in_if.hall_b <= hall[1];
    in_if.hall_c <= hall[0];
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pred = estimate_next(hall);
    pending_estimates.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // drop valid and wait until every estimate has come back
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write both registers while the block is idle
  task automatic program_regs(input logic [TS_W-1:0] ts, input logic [CFG_DATA_W-1:0] ofs);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SAMPLE_PERIOD;
    cfg_data <= ts;
    @(negedge clk);
    cfg_idx  <= REG_ANGLE_OFFSET;
    cfg_data <= ofs;
    @(negedge clk);
    cfg_we   <= 1'b0;
    ts_q  = ts;
    ofs_q = ofs[OFFSET_W-1:0];
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // output side: random stall once a result is waiting
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = stall_en ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        do @(posedge clk); while (out_if.valid !== 1'b1);
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    hsse_res_t exp_res;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_estimates.size() == 0) begin
        note_mismatch($sformatf("unexpected beat: sector %0d speed %h angle %0d",
                                out_if.sector, out_if.speed, out_if.angle));
      end else begin
        exp_res = pending_estimates.pop_front();
        if (out_if.sector !== exp_res.sector || out_if.speed !== exp_res.speed ||
            out_if.angle !== exp_res.angle) begin
          note_mismatch($sformatf(
            "mismatch: expected sector %0d speed %h angle %0d, got sector %0d speed %h angle %0d",
            exp_res.sector, exp_res.speed, exp_res.angle,
            out_if.sector, out_if.speed, out_if.angle));
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("** hall_sector_speed_angle_estimator_top: FAILED **");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int          sent;
    int          n_beats;
    int          pos;
    int          dwell;
    int          pick;
    int          ofs_val;
    logic [2:0]  hall;
    logic [31:0] ts;
    logic [19:0] ofs20;

    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.hall_a = 1'b0;
    in_if.hall_b = 1'b0;
    in_if.hall_c = 1'b0;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    stall_en     = 1'b1;
    ts_q          = TS_RESET;
    ofs_q         = OFFSET_RESET;
    tick_cnt_q    = '0;
    odd_change_q  = 1'b0;
    prev_sector_q = '0;
    fine_q        = '0;
    prev_speed_q  = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_idle();
        program_regs(DIRECTED[i].ts, DIRECTED[i].ofs);
      end else begin
        send_hall(DIRECTED[i].hall, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // random phases, each with its own register setting
    sent  = 0;
    pos   = 0;
    dwell = 0;
    while (sent < RANDOM_BEATS) begin
      wait_idle();
      case ($urandom_range(0, 6))
        0:       ts = 32'd1;
        1:       ts = 32'hFFFF_FFFF;
        2:       ts = TS_RESET;
        3:       ts = $urandom;
        4:       ts = $urandom_range(1, 200000);
        5:       ts = 32'd0;
        default: ts = $urandom_range(200000, 50000000);
      endcase
      case ($urandom_range(0, 4))
        0:       ofs_val = 0;
        1:       ofs_val = 411775;
        2:       ofs_val = -411775;
        3:       ofs_val = int'($urandom_range(0, 823550)) - 411775;
        default: ofs_val = int'($urandom);
      endcase
      ofs20 = ofs_val[19:0];
      program_regs(ts, {12'($urandom), ofs20});
      stall_en = ($urandom_range(0, 3) != 0);
      n_beats = $urandom_range(40, 160);
      repeat (n_beats) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // invalid hall code
          hall = $urandom_range(0, 1) ? 3'b111 : 3'b000;
        end else if (pick < 14) begin
          hall = 3'($urandom_range(0, 7));
        end else begin
          // rotation with random dwell, sometimes backward
          if (dwell == 0) begin
            if ($urandom_range(0, 9) == 0) pos = (pos + 5) % 6;
            else pos = (pos + 1) % 6;
            dwell = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
          end
          hall = ROTATION[pos];
          dwell--;
        end
        send_hall(hall, 1'b0, NO_WANT);
        sent++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && pending_estimates.size() == 0) begin
      $display("** hall_sector_speed_angle_estimator_top: PASSED **");
    end else begin
      $display("** hall_sector_speed_angle_estimator_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/hsse_pkg.sv
sv/hsse_if.sv
sv/hsse_addsub.sv
sv/hsse_core.sv
sv/hall_sector_speed_angle_estimator_top.sv
dv/tb_top.sv
